>>> hw/rtl/lfu_gct_pkg.sv
// Shared types and constants for the glyph cache tag and replacement store.
// No dependencies; the top level and the main-store scanner both import it.
`default_nettype none

package lfu_gct_pkg;

    localparam int CODE_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int SLOT_W      = 8;
    localparam int ENTRIES_DEF = 256;
    localparam int ASCII_DEF   = 128;

    localparam logic [COUNT_W-1:0] COUNT_CEIL  = 16'hfffe;
    localparam logic [COUNT_W-1:0] COUNT_START = 16'hffff;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // Request from the top level to the main-store scanner.
    typedef struct packed {
        logic              start;
        logic              flush;
        logic [CODE_W-1:0] code;
    } t_main_req;

    // Result of one main-store lookup, valid while done is high.
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              rep_valid;
        logic [CODE_W-1:0] rep_code;
    } t_main_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/lfu_glyph_cache_tags_unit.sv
// Top level of the glyph cache tag store: handshakes, ASCII direct-mapped store, output register.
// Depends on lfu_gct_pkg and instantiates lfu_gct_main for the main store.
//
//   Channel  | Direction | Handshake        | Beat
//   ---------+-----------+------------------+-------------------------------------------
//   in       | input     | valid / stall    | req_type, char_code
//   out      | output    | valid / stall    | hit, in_ascii_store, slot, replaced_valid/_code
//   cfg      | input     | valid / ready    | ascii_base
//
// One request is worked on at a time. A main-store lookup scans up to fill_level entries
// (at most ENTRIES) in turn, through the single read port of the main tag/count memory.
// Reset is synchronous and active low; it clears the fill level and ASCII valid bits.
// A result waits in the output register while the out channel is stalled; the next
// request is still accepted and held in its final state until the register frees.
`default_nettype none

module lfu_glyph_cache_tags_unit #(
    parameter int ENTRIES       = lfu_gct_pkg::ENTRIES_DEF,
    parameter int ASCII_ENTRIES = lfu_gct_pkg::ASCII_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [lfu_gct_pkg::CODE_W-1:0]  i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_req_type,
    input  wire  [lfu_gct_pkg::CODE_W-1:0]  i_char_code,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_hit,
    output logic                            o_in_ascii_store,
    output logic [lfu_gct_pkg::SLOT_W-1:0]  o_slot,
    output logic                            o_replaced_valid,
    output logic [lfu_gct_pkg::CODE_W-1:0]  o_replaced_code
);
    import lfu_gct_pkg::*;

    localparam int AW = (ASCII_ENTRIES > 1) ? $clog2(ASCII_ENTRIES) : 1;
    localparam logic [CODE_W:0] AE_LIM = (CODE_W+1)'(ASCII_ENTRIES);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ASCII_RD  = 3'd1;
    localparam logic [2:0] S_ASCII_CMP = 3'd2;
    localparam logic [2:0] S_MAIN      = 3'd3;
    localparam logic [2:0] S_OUT       = 3'd4;

    // ASCII store memory with per-entry valid bits; an invalid entry reads as tag zero.
    logic [CODE_W-1:0]        r_amem [ASCII_ENTRIES];
    logic [CODE_W-1:0]        r_ard;
    logic [ASCII_ENTRIES-1:0] r_avalid, n_avalid;

    logic [2:0]        r_state, n_state;
    logic [CODE_W-1:0] r_base;
    logic [CODE_W-1:0] r_code, n_code;
    logic [AW-1:0]     r_aslot, n_aslot;

    logic              r_res_hit, n_res_hit;
    logic              r_res_ascii, n_res_ascii;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic              r_res_rv, n_res_rv;
    logic [CODE_W-1:0] r_res_rc, n_res_rc;

    logic              r_o_valid, n_o_valid;
    logic              r_o_hit;
    logic              r_o_ascii;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_rv;
    logic [CODE_W-1:0] r_o_rc;

    logic              in_acc;
    logic              out_free;
    logic              load_out;
    logic [CODE_W-1:0] offset;
    logic              in_window;
    logic [CODE_W-1:0] old_tag;
    logic              a_wen;

    t_main_req main_req;
    t_main_rsp main_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_o_valid || !i_out_stall;
    assign load_out    = (r_state == S_OUT) && out_free;

    // Window test: no wrap past the top of the code space.
    assign offset    = i_char_code - r_base;
    assign in_window = (i_char_code >= r_base) && ({1'b0, offset} < AE_LIM);
    assign old_tag   = r_avalid[r_aslot] ? r_ard : '0;

    // Request sequencer.
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_aslot     = r_aslot;
        n_avalid    = r_avalid;
        n_res_hit   = r_res_hit;
        n_res_ascii = r_res_ascii;
        n_res_slot  = r_res_slot;
        n_res_rv    = r_res_rv;
        n_res_rc    = r_res_rc;
        main_req    = '0;
        a_wen       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_code = i_char_code;
                    if (i_req_type == REQ_FLUSH) begin
                        n_avalid       = '0;
                        main_req.flush = 1'b1;
                        n_res_hit      = 1'b0;
                        n_res_ascii    = 1'b0;
                        n_res_slot     = '0;
                        n_res_rv       = 1'b0;
                        n_res_rc       = '0;
                        n_state        = S_OUT;
                    end else if (in_window) begin
                        n_aslot = offset[AW-1:0];
                        n_state = S_ASCII_RD;
                    end else begin
                        main_req.start = 1'b1;
                        main_req.code  = i_char_code;
                        n_state        = S_MAIN;
                    end
                end
            end
            S_ASCII_RD: begin
                n_state = S_ASCII_CMP;
            end
            S_ASCII_CMP: begin
                n_res_ascii = 1'b1;
                n_res_slot  = SLOT_W'(r_aslot);
                if (old_tag == r_code) begin
                    n_res_hit = 1'b1;
                    n_res_rv  = 1'b0;
                    n_res_rc  = '0;
                end else begin
                    a_wen             = 1'b1;
                    n_avalid[r_aslot] = 1'b1;
                    n_res_hit         = 1'b0;
                    n_res_rv          = (old_tag != '0);
                    n_res_rc          = old_tag;
                end
                n_state = S_OUT;
            end
            S_MAIN: begin
                if (main_rsp.done) begin
                    n_res_hit   = main_rsp.hit;
                    n_res_ascii = 1'b0;
                    n_res_slot  = main_rsp.slot;
                    n_res_rv    = main_rsp.rep_valid;
                    n_res_rc    = main_rsp.rep_code;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken.
    always_comb begin
        n_o_valid = r_o_valid;
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    // ASCII store memory: write on a miss, registered read of the selected slot.
    always_ff @(posedge i_clk) begin
        if (a_wen) begin
            r_amem[r_aslot] <= r_code;
        end
        r_ard <= r_amem[r_aslot];
    end

    // Control registers and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_avalid  <= '0;
            r_o_valid <= 1'b0;
            r_base    <= '0;
        end else begin
            r_state   <= n_state;
            r_avalid  <= n_avalid;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_aslot     <= n_aslot;
        r_res_hit   <= n_res_hit;
        r_res_ascii <= n_res_ascii;
        r_res_slot  <= n_res_slot;
        r_res_rv    <= n_res_rv;
        r_res_rc    <= n_res_rc;
        if (load_out) begin
            r_o_hit   <= r_res_hit;
            r_o_ascii <= r_res_ascii;
            r_o_slot  <= r_res_slot;
            r_o_rv    <= r_res_rv;
            r_o_rc    <= r_res_rc;
        end
    end

    // Main store and its scan sequencer.
    lfu_gct_main #(
        .ENTRIES (ENTRIES)
    ) u_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (main_req),
        .o_rsp   (main_rsp)
    );

    assign o_out_valid      = r_o_valid;
    assign o_hit            = r_o_hit;
    assign o_in_ascii_store = r_o_ascii;
    assign o_slot           = r_o_slot;
    assign o_replaced_valid = r_o_rv;
    assign o_replaced_code  = r_o_rc;

endmodule

`default_nettype wire

>>> hw/rtl/lfu_gct_main.sv
// Main store of the glyph cache: tag/count memory, fill level and the scan sequencer.
// Depends on lfu_gct_pkg for the request and response structs and constants.
`default_nettype none

module lfu_gct_main #(
    parameter int ENTRIES = lfu_gct_pkg::ENTRIES_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire lfu_gct_pkg::t_main_req i_req,
    output lfu_gct_pkg::t_main_rsp o_rsp
);
    import lfu_gct_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int FW = EW + 1;
    localparam int MW = CODE_W + COUNT_W;
    localparam logic [FW-1:0] FULL = FW'(ENTRIES);

    localparam logic [0:0] M_IDLE = 1'b0;
    localparam logic [0:0] M_SCAN = 1'b1;

    // Each word holds {tag, use count}.
    logic [MW-1:0] r_mem [ENTRIES];
    logic [MW-1:0] r_rd_data;

    logic [0:0]         r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [EW-1:0]      r_pidx, n_pidx;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [COUNT_W-1:0] r_best, n_best;
    logic [EW-1:0]      r_best_idx, n_best_idx;
    logic [CODE_W-1:0]  r_best_tag, n_best_tag;
    t_main_rsp          r_rsp, n_rsp;

    logic               w_en;
    logic [EW-1:0]      w_addr;
    logic [MW-1:0]      w_data;

    logic [CODE_W-1:0]  rd_tag;
    logic [COUNT_W-1:0] rd_cnt;
    logic [COUNT_W-1:0] cnt_inc;

    assign rd_tag  = r_rd_data[MW-1:COUNT_W];
    assign rd_cnt  = r_rd_data[COUNT_W-1:0];
    assign cnt_inc = (rd_cnt < COUNT_CEIL) ? rd_cnt + 1'b1 : rd_cnt;

    // Scan sequencer: one read issued per cycle, its data checked in the next cycle.
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_code     = r_code;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_best_tag = r_best_tag;
        n_rsp      = '0;
        w_en       = 1'b0;
        w_addr     = r_pidx;
        w_data     = r_rd_data;
        case (r_state)
            M_IDLE: begin
                if (i_req.flush) begin
                    n_fill = '0;
                end else if (i_req.start) begin
                    n_code     = i_req.code;
                    n_addr     = '0;
                    n_best     = COUNT_START;
                    n_best_idx = '0;
                    n_best_tag = '0;
                    n_state    = M_SCAN;
                end
            end
            M_SCAN: begin
                if (r_pend && (rd_tag == r_code)) begin
                    // First matching entry: bump its count and finish.
                    w_en          = 1'b1;
                    w_addr        = r_pidx;
                    w_data        = {rd_tag, cnt_inc};
                    n_rsp.done    = 1'b1;
                    n_rsp.hit     = 1'b1;
                    n_rsp.slot    = SLOT_W'(r_pidx);
                    n_state       = M_IDLE;
                end else begin
                    // Track the first entry with the lowest count.
                    if (r_pend && (rd_cnt < r_best)) begin
                        n_best     = rd_cnt;
                        n_best_idx = r_pidx;
                        n_best_tag = rd_tag;
                    end
                    if (r_addr < r_fill) begin
                        n_pend = 1'b1;
                        n_pidx = r_addr[EW-1:0];
                        n_addr = r_addr + 1'b1;
                    end else if (!r_pend) begin
                        // Nothing left in flight: miss, fill or evict.
                        w_en       = 1'b1;
                        w_data     = {r_code, {COUNT_W{1'b0}}};
                        n_rsp.done = 1'b1;
                        n_state    = M_IDLE;
                        if (r_fill < FULL) begin
                            w_addr     = r_fill[EW-1:0];
                            n_rsp.slot = SLOT_W'(r_fill[EW-1:0]);
                            n_fill     = r_fill + 1'b1;
                        end else begin
                            w_addr         = r_best_idx;
                            n_rsp.slot     = SLOT_W'(r_best_idx);
                            n_rsp.rep_valid = 1'b1;
                            n_rsp.rep_code = r_best_tag;
                        end
                    end
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_addr[EW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_rsp   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_rsp   <= n_rsp;
        end
    end

    // Scan datapath registers.
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_code     <= n_code;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_tag <= n_best_tag;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

>>> hw/rtl/lfu_gct_checker.sv
// Port-level checker for the glyph cache tag store, bound to the top level.
// Depends on lfu_gct_pkg for field widths; sees only the top level's ports.
`default_nettype none

module lfu_gct_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             o_in_stall,
    input wire                             o_out_valid,
    input wire                             i_out_stall,
    input wire                             o_hit,
    input wire [lfu_gct_pkg::SLOT_W-1:0]   o_slot,
    input wire                             o_replaced_valid,
    input wire [lfu_gct_pkg::CODE_W-1:0]   o_replaced_code
);
    import lfu_gct_pkg::*;

    // A stalled result beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its slot and replaced code.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_slot) && $stable(o_replaced_code))
        else $error("result payload changed while stalled");

    // One request at a time: the input stalls right after an accepted beat.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted while one is in progress");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_replaced_valid))
        else $error("hit reported together with an eviction");

    // Without an eviction the replaced code reads zero.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_replaced_valid |-> (o_replaced_code == '0))
        else $error("replaced code nonzero without an eviction");

endmodule

bind lfu_glyph_cache_tags_unit lfu_gct_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_hit            (o_hit),
    .o_slot           (o_slot),
    .o_replaced_valid (o_replaced_valid),
    .o_replaced_code  (o_replaced_code)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for lfu_glyph_cache_tags_unit: directed, random and long-run traffic.
// Depends on lfu_gct_pkg and the RTL of the unit; predicts every result beat in a local model.
`timescale 1ns / 100ps

module tb;
    import lfu_gct_pkg::*;

    localparam int NUM_ENTRIES = ENTRIES_DEF;
    localparam int NUM_ASCII   = ASCII_DEF;

    // One result beat as the unit should present it.
    typedef struct packed {
        logic              hit;
        logic              in_ascii;
        logic [SLOT_W-1:0] slot;
        logic              rep_valid;
        logic [CODE_W-1:0] rep_code;
    } t_glyph_result;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [CODE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              i_req_type  = REQ_LOOKUP;
    logic [CODE_W-1:0] i_char_code = '0;
    logic              i_out_stall = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_hit;
    logic              o_in_ascii_store;
    logic [SLOT_W-1:0] o_slot;
    logic              o_replaced_valid;
    logic [CODE_W-1:0] o_replaced_code;

    // Local copy of the cache state used for prediction.
    logic [CODE_W-1:0]  ascii_base_q;
    logic [CODE_W-1:0]  main_tags   [NUM_ENTRIES];
    logic [COUNT_W-1:0] main_counts [NUM_ENTRIES];
    logic [CODE_W-1:0]  ascii_tags_q[NUM_ASCII];
    int                 main_fill;

    t_glyph_result     pending_results[$];
    logic [CODE_W-1:0] recent_codes[$];
    int                error_count   = 0;
    int                send_idle_pct = 0;
    int                stall_pct     = 0;

    lfu_glyph_cache_tags_unit #(
        .ENTRIES       (NUM_ENTRIES),
        .ASCII_ENTRIES (NUM_ASCII)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_char_code      (i_char_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_hit            (o_hit),
        .o_in_ascii_store (o_in_ascii_store),
        .o_slot           (o_slot),
        .o_replaced_valid (o_replaced_valid),
        .o_replaced_code  (o_replaced_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the unit hangs.
    initial begin
        #20_000_000;
        $display("lfu_glyph_cache_tags_unit test failed");
        $finish;
    end

    function automatic void clear_cache();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            main_tags[i]   = '0;
            main_counts[i] = '0;
        end
        for (int i = 0; i < NUM_ASCII; i++) begin
            ascii_tags_q[i] = '0;
        end
        main_fill = 0;
    endfunction

    function automatic bit in_window(input logic [CODE_W-1:0] code);
        return (code >= ascii_base_q) && (int'(code) - int'(ascii_base_q) < NUM_ASCII);
    endfunction

    // Applies one request to the local state and returns the result it should give.
    function automatic t_glyph_result predict_lookup(input logic req,
                                                     input logic [CODE_W-1:0] code);
        t_glyph_result r;
        int            pos;
        int            lowest;
        r   = '0;
        pos = -1;
        if (req == REQ_FLUSH) begin
            clear_cache();
        end else if (in_window(code)) begin
            pos        = int'(code) - int'(ascii_base_q);
            r.in_ascii = 1'b1;
            r.slot     = pos[SLOT_W-1:0];
            if (ascii_tags_q[pos] == code) begin
                r.hit = 1'b1;
            end else begin
                // A cleared slot holds tag zero and is not reported as replaced.
                if (ascii_tags_q[pos] != '0) begin
                    r.rep_valid = 1'b1;
                    r.rep_code  = ascii_tags_q[pos];
                end
                ascii_tags_q[pos] = code;
            end
        end else begin
            for (int i = 0; i < main_fill; i++) begin
                if (pos < 0 && main_tags[i] == code) pos = i;
            end
            if (pos >= 0) begin
                r.hit  = 1'b1;
                r.slot = pos[SLOT_W-1:0];
                if (main_counts[pos] < COUNT_CEIL) main_counts[pos] = main_counts[pos] + 1'b1;
            end else begin
                if (main_fill < NUM_ENTRIES) begin
                    pos       = main_fill;
                    main_fill = main_fill + 1;
                end else begin
                    // Victim is the first entry holding the lowest count.
                    lowest = int'(COUNT_START);
                    pos    = 0;
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (int'(main_counts[i]) < lowest) begin
                            lowest = int'(main_counts[i]);
                            pos    = i;
                        end
                    end
                    r.rep_valid = 1'b1;
                    r.rep_code  = main_tags[pos];
                end
                main_tags[pos]   = code;
                main_counts[pos] = '0;
                r.slot           = pos[SLOT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] main_code();
        logic [CODE_W-1:0] code;
        code = CODE_W'($urandom_range(0, 65535));
        while (in_window(code)) code = CODE_W'($urandom_range(0, 65535));
        return code;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Sends one request beat and records its predicted result once accepted.
    task automatic send_request(input logic req, input logic [CODE_W-1:0] code);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_char_code <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_lookup(req, code));
    endtask

    task automatic lookup(input logic [CODE_W-1:0] code);
        send_request(REQ_LOOKUP, code);
    endtask

    // Stops sending until every predicted result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ascii_base(input logic [CODE_W-1:0] base);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        ascii_base_q  = base;
    endtask

    // Receiver side: random stall per cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compares every result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_glyph_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("in_ascii_store", want.in_ascii, o_in_ascii_store);
                check_field("slot", want.slot, o_slot);
                check_field("replaced_valid", want.rep_valid, o_replaced_valid);
                check_field("replaced_code", want.rep_code, o_replaced_code);
            end
        end
    end

    // ASCII store with base zero: tag zero hits at slot zero, then miss and hit.
    task automatic test_ascii_store();
        lookup(16'd0);
        lookup(16'd127);
        lookup(16'd127);
        lookup(16'd5);
        lookup(16'd5);
    endtask

    // Main store: fill of free entries and hits, including the top code.
    task automatic test_main_store();
        lookup(16'd128);
        lookup(16'hffff);
        lookup(16'd128);
        lookup(16'hffff);
        lookup(16'd200);
    endtask

    // Flush ignores its code and clears both stores.
    task automatic test_flush();
        send_request(REQ_FLUSH, 16'hffff);
        lookup(16'd128);
        lookup(16'd127);
    endtask

    // Full window at the top of the code space, truncated window, and no wrap past 65535.
    task automatic test_window_edges();
        write_ascii_base(16'hff80);
        lookup(16'hffff);
        lookup(16'hff80);
        lookup(16'hff7f);
        lookup(16'd0);
        write_ascii_base(16'hff7f);
        lookup(16'hfffe);
        lookup(16'hffff);
        write_ascii_base(16'hffff);
        lookup(16'hffff);
        lookup(16'd0);
    endtask

    // Flushes and fills the main store, then mixes hits and misses that evict by count with window lookups.
    task automatic test_eviction();
        int pick;
        send_request(REQ_FLUSH, CODE_W'($urandom_range(0, 65535)));
        while (main_fill < NUM_ENTRIES) lookup(main_code());
        repeat (300) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) lookup(main_tags[$urandom_range(0, 31)]);
            else if (pick < 45) lookup(main_tags[$urandom_range(0, NUM_ENTRIES - 1)]);
            else if (pick < 85) lookup(main_code());
            else lookup(ascii_base_q + CODE_W'($urandom_range(0, NUM_ASCII - 1)));
        end
    endtask

    // Mixed traffic: flushes, window codes, edge codes, fresh and repeated main-store codes.
    task automatic random_traffic(input int count);
        int                pick;
        int                offset;
        logic [CODE_W-1:0] code;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_request(REQ_FLUSH, CODE_W'($urandom_range(0, 65535)));
            end else if (pick < 25) begin
                offset = int'(ascii_base_q) + $urandom_range(0, NUM_ASCII - 1);
                code   = (offset > 65535) ? CODE_W'($urandom_range(0, 65535)) : CODE_W'(offset);
                lookup(code);
            end else if (pick < 35) begin
                case ($urandom_range(0, 5))
                    0:       code = 16'd0;
                    1:       code = 16'hffff;
                    2:       code = ascii_base_q;
                    3:       code = ascii_base_q - 1'b1;
                    4:       code = ascii_base_q + CODE_W'(NUM_ASCII - 1);
                    default: code = ascii_base_q + CODE_W'(NUM_ASCII);
                endcase
                lookup(code);
            end else begin
                if (pick < 60 || recent_codes.size() == 0) code = main_code();
                else code = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
                lookup(code);
                recent_codes.push_back(code);
                if (recent_codes.size() > 200) void'(recent_codes.pop_front());
            end
            if ($urandom_range(0, 199) == 0) drain();
        end
    endtask

    initial begin
        ascii_base_q = '0;
        clear_cache();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver stalls heavily.
        send_idle_pct = 20;
        stall_pct     = 81;
        test_ascii_store();
        test_main_store();
        test_flush();
        test_window_edges();
        random_traffic(300);

        // Sender idles heavily, receiver stalls lightly.
        send_idle_pct = 81;
        stall_pct     = 20;
        write_ascii_base(CODE_W'($urandom_range(0, 65535)));
        test_eviction();
        random_traffic(300);

        // Full rate on both sides.
        send_idle_pct = 0;
        stall_pct     = 0;
        write_ascii_base(16'd0);
        random_traffic(300);

        drain();
        repeat (NUM_ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("lfu_glyph_cache_tags_unit test passed");
        end else begin
            $display("lfu_glyph_cache_tags_unit test failed");
        end
        $finish;
    end

endmodule

>>> lfu_glyph_cache_tags_unit.f
hw/rtl/lfu_gct_pkg.sv
hw/rtl/lfu_gct_main.sv
hw/rtl/lfu_glyph_cache_tags_unit.sv
hw/rtl/lfu_gct_checker.sv
tb/tb.sv
